// ===== sv/aspl_pkg.sv =====
// Shared types, constants and arithmetic helpers of the affine shape lowering block.
package aspl_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);
    // Bezier circle control factor in Q(FRAC_BITS), rounded from a Q32 value
    localparam logic [63:0] KAPPA_Q32 = 64'd2372044939;
    localparam logic [63:0] KAPPA_Q =
        (KAPPA_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [31:0] KAPPA_C = 32'(KAPPA_Q);

    // input opcodes
    localparam logic [1:0] OP_PATH = 2'd0;
    localparam logic [1:0] OP_POLY = 2'd1;
    localparam logic [1:0] OP_RECT = 2'd2;
    localparam logic [1:0] OP_ELL  = 2'd3;

    // path point kinds
    localparam logic [1:0] PK_BEZ   = 2'd2;
    localparam logic [1:0] PK_CLOSE = 2'd3;

    // result kinds
    localparam logic [2:0] K_POLY   = 3'd0;
    localparam logic [2:0] K_MOVE   = 3'd1;
    localparam logic [2:0] K_LINE   = 3'd2;
    localparam logic [2:0] K_BEZ    = 3'd3;
    localparam logic [2:0] K_CLOSE  = 3'd4;
    localparam logic [2:0] K_RECT   = 3'd5;
    localparam logic [2:0] K_ELL    = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_XX   = 3'd0;
    localparam logic [2:0] REG_XY   = 3'd1;
    localparam logic [2:0] REG_YX   = 3'd2;
    localparam logic [2:0] REG_YY   = 3'd3;
    localparam logic [2:0] REG_TX   = 3'd4;
    localparam logic [2:0] REG_TY   = 3'd5;
    localparam logic [2:0] REG_SAME = 3'd6;

    // how the final stage builds a result
    localparam logic [1:0] M_PASS = 2'd0;  // p/q carried as x,y,w,h
    localparam logic [1:0] M_XF   = 2'd1;  // transformed p
    localparam logic [1:0] M_RECT = 2'd2;  // min/max of transformed p and q
    localparam logic [1:0] M_ELL  = 2'd3;  // transformed p, scaled radii in q

    typedef struct packed {
        logic [1:0]        mode;
        logic [2:0]        kind;
        logic              first;
        logic              last;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } sub_t;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sh7FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -67'sh80000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // arc point tables: index into {r, k, 0, -k, -r}
    function automatic logic [2:0] arc_x(input logic [3:0] i);
        logic [2:0] r;
        case (i)
            4'd2, 4'd10: r = 3'd1;
            4'd3, 4'd9:  r = 3'd2;
            4'd4, 4'd8:  r = 3'd3;
            4'd5, 4'd6, 4'd7: r = 3'd4;
            default:     r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] arc_y(input logic [3:0] i);
        logic [2:0] r;
        case (i)
            4'd1, 4'd5, 4'd11: r = (i == 4'd1) ? 3'd1 : ((i == 4'd5) ? 3'd1 : 3'd3);
            4'd2, 4'd3, 4'd4:  r = 3'd0;
            4'd0, 4'd6, 4'd12: r = 3'd2;
            4'd7:              r = 3'd3;
            4'd8, 4'd9, 4'd10: r = 3'd4;
            default:           r = 3'd2;
        endcase
        return r;
    endfunction

    function automatic logic signed [33:0] off_sel(input logic [2:0] s,
                                                   input logic signed [31:0] b,
                                                   input logic signed [31:0] k);
        logic signed [33:0] r;
        case (s)
            3'd0:    r = 34'(b);
            3'd1:    r = 34'(k);
            3'd3:    r = -34'(k);
            3'd4:    r = -34'(b);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/affine_shape_to_path_lowering_top.sv =====
// Top level: affine transform and shape lowering pipeline.
//
//  channel | signals                         | item
//  --------+---------------------------------+------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser s_tlast | one geometry element
//  out     | m_tvalid m_tready m_tdata m_tuser m_tlast | one lowered result
//  config  | cfg_we cfg_index cfg_data        | one register write
//
// Seven register stages: input, expander, point, multiply, sum, round, output.
// One result leaves per cycle while the output is not stalled; an element that lowers to n results holds the
// input in the expander until its last result is issued (up to 14 for a sheared ellipse).
// Reset clears valid bits and loads the identity transform.
// A stall on the output freezes every stage at once; nothing is dropped.
module affine_shape_to_path_lowering_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // coord_a_x, coord_a_y, extent_b_x, extent_b_y
    input  logic [4:0]   s_tuser,   // opcode[1:0], path_kind[3:2], first_flag[4]
    input  logic         s_tlast,   // last_flag
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_w, out_h
    output logic [3:0]   m_tuser,   // out_kind[2:0], out_first[3]
    output logic         m_tlast,   // out_last
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import aspl_pkg::*;

    // configuration registers
    logic signed [31:0] xx_reg, xy_reg, yx_reg, yy_reg, tx_reg, ty_reg;
    logic               same_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_reg   <= 32'sd1 <<< FRAC_BITS;
            xy_reg   <= '0;
            yx_reg   <= '0;
            yy_reg   <= 32'sd1 <<< FRAC_BITS;
            tx_reg   <= '0;
            ty_reg   <= '0;
            same_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_XX:   xx_reg   <= cfg_data;
                REG_XY:   xy_reg   <= cfg_data;
                REG_YX:   yx_reg   <= cfg_data;
                REG_YY:   yy_reg   <= cfg_data;
                REG_TX:   tx_reg   <= cfg_data;
                REG_TY:   ty_reg   <= cfg_data;
                REG_SAME: same_reg <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    logic axis;
    assign axis = (xy_reg == '0) && (yx_reg == '0);

    // global advance: output register free or being drained
    logic en;
    assign en = !m_tvalid || m_tready;

    // ---------------- stage 1: input register and control factor products
    logic               s1_valid_reg;
    logic [1:0]         s1_op_reg, s1_pk_reg;
    logic               s1_first_reg, s1_last_reg;
    logic signed [31:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic signed [63:0] s1_kpx_reg, s1_kpy_reg;

    // ---------------- stage 2: expander
    logic               s2_valid_reg;
    logic [1:0]         s2_op_reg, s2_pk_reg;
    logic               s2_first_reg, s2_last_reg;
    logic signed [31:0] s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;
    logic signed [31:0] s2_r_reg, s2_b_reg, s2_kx_reg, s2_ky_reg;
    logic [3:0]         cnt_reg;
    logic [3:0]         s2_count;
    logic               s2_done, s2_load, s1_load;

    assign s2_done  = (cnt_reg == s2_count - 4'd1);
    assign s2_load  = en && (!s2_valid_reg || s2_done);
    assign s1_load  = en && (!s1_valid_reg || s2_load);
    assign s_tready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg    <= s_tuser[1:0];
            s1_pk_reg    <= s_tuser[3:2];
            s1_first_reg <= s_tuser[4];
            s1_last_reg  <= s_tlast;
            s1_ax_reg    <= s_tdata[31:0];
            s1_ay_reg    <= s_tdata[63:32];
            s1_bx_reg    <= s_tdata[95:64];
            s1_by_reg    <= s_tdata[127:96];
            s1_kpx_reg   <= 64'($signed(s_tdata[95:64])) * 64'(KAPPA_C);
            s1_kpy_reg   <= 64'($signed(s_tdata[127:96])) * 64'(KAPPA_C);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
            cnt_reg      <= '0;
        end
        else if (en && s2_valid_reg)
            cnt_reg <= cnt_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_pk_reg    <= s1_pk_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_ax_reg    <= s1_ax_reg;
            s2_ay_reg    <= s1_ay_reg;
            s2_bx_reg    <= s1_bx_reg;
            s2_by_reg    <= s1_by_reg;
            s2_r_reg     <= sat32(67'(s1_ax_reg) + 67'(s1_bx_reg));
            s2_b_reg     <= sat32(67'(s1_ay_reg) + 67'(s1_by_reg));
            s2_kx_reg    <= sat32((67'(s1_kpx_reg) + HALF) >>> FRAC_BITS);
            s2_ky_reg    <= sat32((67'(s1_kpy_reg) + HALF) >>> FRAC_BITS);
        end
    end

    // result count and current sub-item
    logic lower;
    sub_t sub;
    assign lower = !same_reg && !axis;

    always_comb
    begin
        case (s2_op_reg)
            OP_POLY: s2_count = (lower && s2_last_reg) ? 4'd2 : 4'd1;
            OP_RECT: s2_count = lower ? 4'd5 : 4'd1;
            OP_ELL:  s2_count = lower ? 4'd14 : 4'd1;
            default: s2_count = 4'd1;
        endcase
    end

    always_comb
    begin
        sub       = '0;
        sub.mode  = M_PASS;
        sub.kind  = K_CLOSE;
        sub.last  = s2_done;
        case (s2_op_reg)
            OP_PATH:
            begin
                if (s2_pk_reg != PK_CLOSE)
                begin
                    sub.mode  = same_reg ? M_PASS : M_XF;
                    sub.kind  = 3'(s2_pk_reg) + 3'd1;
                    sub.first = (s2_pk_reg == PK_BEZ) ? s2_first_reg : 1'b0;
                    sub.px    = s2_ax_reg;
                    sub.py    = s2_ay_reg;
                end
            end
            OP_POLY:
            begin
                if (cnt_reg == 4'd0)
                begin
                    sub.mode = same_reg ? M_PASS : M_XF;
                    sub.kind = !lower ? K_POLY : (s2_first_reg ? K_MOVE : K_LINE);
                    sub.px   = s2_ax_reg;
                    sub.py   = s2_ay_reg;
                end
            end
            OP_RECT:
            begin
                if (same_reg)
                begin
                    sub.kind = K_RECT;
                    sub.px   = s2_ax_reg;
                    sub.py   = s2_ay_reg;
                    sub.qx   = s2_bx_reg;
                    sub.qy   = s2_by_reg;
                end
                else if (axis)
                begin
                    sub.mode = M_RECT;
                    sub.kind = K_RECT;
                    sub.px   = s2_ax_reg;
                    sub.py   = s2_ay_reg;
                    sub.qx   = s2_r_reg;
                    sub.qy   = s2_b_reg;
                end
                else if (cnt_reg != 4'd4)
                begin
                    sub.mode = M_XF;
                    sub.kind = (cnt_reg == 4'd0) ? K_MOVE : K_LINE;
                    sub.px   = (cnt_reg == 4'd1 || cnt_reg == 4'd2) ? s2_r_reg : s2_ax_reg;
                    sub.py   = (cnt_reg == 4'd2 || cnt_reg == 4'd3) ? s2_b_reg : s2_ay_reg;
                end
            end
            default:
            begin
                if (same_reg)
                begin
                    sub.kind = K_ELL;
                    sub.px   = s2_ax_reg;
                    sub.py   = s2_ay_reg;
                    sub.qx   = s2_bx_reg;
                    sub.qy   = s2_by_reg;
                end
                else if (axis)
                begin
                    sub.mode = M_ELL;
                    sub.kind = K_ELL;
                    sub.px   = s2_ax_reg;
                    sub.py   = s2_ay_reg;
                    sub.qx   = s2_bx_reg;
                    sub.qy   = s2_by_reg;
                end
                else if (cnt_reg != 4'd13)
                begin
                    sub.mode  = M_XF;
                    sub.kind  = (cnt_reg == 4'd0) ? K_MOVE : K_BEZ;
                    sub.first = (cnt_reg == 4'd1) || (cnt_reg == 4'd4) ||
                                (cnt_reg == 4'd7) || (cnt_reg == 4'd10);
                    sub.px    = sat32(67'(34'(s2_ax_reg) +
                                off_sel(arc_x(cnt_reg), s2_bx_reg, s2_kx_reg)));
                    sub.py    = sat32(67'(34'(s2_ay_reg) +
                                off_sel(arc_y(cnt_reg), s2_by_reg, s2_ky_reg)));
                end
            end
        endcase
    end

    // ---------------- stages 3..6: point, multiply, sum, round
    logic               s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg;
    sub_t               s3_reg, s4_reg, s5_reg, s6_reg;
    logic signed [64:0] m_pa_reg, m_pb_reg, m_pc_reg, m_pd_reg;
    logic signed [64:0] m_qa_reg, m_qb_reg, m_qc_reg, m_qd_reg;
    logic signed [65:0] s_px_reg, s_py_reg, s_qx_reg, s_qy_reg;
    logic signed [31:0] r_px_reg, r_py_reg, r_qx_reg, r_qy_reg;
    logic signed [32:0] abs_xx, abs_yy, cq_xx, cq_xy, cq_yx, cq_yy;
    logic               s3_ell, s5_ell;

    assign abs_xx = xx_reg[31] ? -33'(xx_reg) : 33'(xx_reg);
    assign abs_yy = yy_reg[31] ? -33'(yy_reg) : 33'(yy_reg);
    assign s3_ell = (s3_reg.mode == M_ELL);
    assign s5_ell = (s5_reg.mode == M_ELL);
    // second point of an unsheared ellipse carries radii scaled by |xx|, |yy|
    assign cq_xx  = s3_ell ? abs_xx : 33'(xx_reg);
    assign cq_xy  = s3_ell ? '0 : 33'(xy_reg);
    assign cq_yx  = s3_ell ? '0 : 33'(yx_reg);
    assign cq_yy  = s3_ell ? abs_yy : 33'(yy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg   <= sub;
            // products
            s4_reg   <= s3_reg;
            m_pa_reg <= 65'(s3_reg.px) * 65'(xx_reg);
            m_pb_reg <= 65'(s3_reg.py) * 65'(xy_reg);
            m_pc_reg <= 65'(s3_reg.px) * 65'(yx_reg);
            m_pd_reg <= 65'(s3_reg.py) * 65'(yy_reg);
            m_qa_reg <= 65'(s3_reg.qx) * 65'(cq_xx);
            m_qb_reg <= 65'(s3_reg.qy) * 65'(cq_xy);
            m_qc_reg <= 65'(s3_reg.qx) * 65'(cq_yx);
            m_qd_reg <= 65'(s3_reg.qy) * 65'(cq_yy);
            // sums
            s5_reg   <= s4_reg;
            s_px_reg <= 66'(m_pa_reg) + 66'(m_pb_reg);
            s_py_reg <= 66'(m_pc_reg) + 66'(m_pd_reg);
            s_qx_reg <= 66'(m_qa_reg) + 66'(m_qb_reg);
            s_qy_reg <= 66'(m_qc_reg) + 66'(m_qd_reg);
            // round, translate, saturate
            s6_reg   <= s5_reg;
            r_px_reg <= sat32(((67'(s_px_reg) + HALF) >>> FRAC_BITS) + 67'(tx_reg));
            r_py_reg <= sat32(((67'(s_py_reg) + HALF) >>> FRAC_BITS) + 67'(ty_reg));
            r_qx_reg <= sat32(((67'(s_qx_reg) + HALF) >>> FRAC_BITS) +
                              (s5_ell ? 67'sd0 : 67'(tx_reg)));
            r_qy_reg <= sat32(((67'(s_qy_reg) + HALF) >>> FRAC_BITS) +
                              (s5_ell ? 67'sd0 : 67'(ty_reg)));
        end
    end

    // ---------------- stage 7: result assembly into the output register
    logic signed [31:0] lx, hx, ly, hy, ox, oy, ow, oh;

    always_comb
    begin
        lx = (r_px_reg < r_qx_reg) ? r_px_reg : r_qx_reg;
        hx = (r_px_reg < r_qx_reg) ? r_qx_reg : r_px_reg;
        ly = (r_py_reg < r_qy_reg) ? r_py_reg : r_qy_reg;
        hy = (r_py_reg < r_qy_reg) ? r_qy_reg : r_py_reg;
        case (s6_reg.mode)
            M_XF:
            begin
                ox = r_px_reg; oy = r_py_reg; ow = '0; oh = '0;
            end
            M_RECT:
            begin
                ox = lx; oy = ly;
                ow = sat32(67'(hx) - 67'(lx));
                oh = sat32(67'(hy) - 67'(ly));
            end
            M_ELL:
            begin
                ox = r_px_reg; oy = r_py_reg; ow = r_qx_reg; oh = r_qy_reg;
            end
            default:
            begin
                ox = s6_reg.px; oy = s6_reg.py; ow = s6_reg.qx; oh = s6_reg.qy;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (en)
            m_tvalid <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= {oh, ow, oy, ox};
            m_tuser <= {s6_reg.first, s6_reg.kind};
            m_tlast <= s6_reg.last;
        end
    end

`ifndef SYNTHESIS
    // a stall freezes the expander position
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(cnt_reg))
        else $error("expander count moved during a stall");

    // the expander never runs past the last result of its element
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (cnt_reg < s2_count))
        else $error("expander index beyond result count");

    // an unfinished element steps one result per advance
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s2_valid_reg && !s2_done) |=> (cnt_reg == $past(cnt_reg) + 4'd1))
        else $error("expander skipped or repeated a result");
`endif

endmodule

// ===== tb/sv/aspl_checker.sv =====
// Checker for the affine shape lowering block: predicts results and compares them.
module aspl_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [4:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [3:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import aspl_pkg::*;

    localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q = ONE_Q >>> 1;
    localparam longint KAPPA_FX =
        (64'sd2372044939 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] x, y, w, h;
        logic        first;
        logic        last;
    } shape_result_t;

    shape_result_t lowered_q[$];

    // copy of the transform registers
    longint m_xx, m_xy, m_yx, m_yy, m_tx, m_ty;
    bit     m_same;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_q(longint p);
        return clamp32((p + HALF_Q) >>> FRAC_BITS);
    endfunction

    // a*x + b*y + t, each product floored and remainders summed with rounding
    function automatic longint affine_lin(longint a, longint b, longint t,
                                          longint x, longint y);
        longint p1, p2, q1, q2, r;
        p1 = a * x;
        p2 = b * y;
        q1 = p1 >>> FRAC_BITS;
        q2 = p2 >>> FRAC_BITS;
        r  = (p1 - (q1 <<< FRAC_BITS)) + (p2 - (q2 <<< FRAC_BITS)) + HALF_Q;
        return clamp32(q1 + q2 + t + (r >>> FRAC_BITS));
    endfunction

    function automatic void map_point(longint x, longint y, output longint ox,
                                      output longint oy);
        ox = affine_lin(m_xx, m_xy, m_tx, x, y);
        oy = affine_lin(m_yx, m_yy, m_ty, x, y);
    endfunction

    function automatic void add_result(logic [2:0] kind, longint x, longint y,
                                       longint w, longint h, logic first);
        shape_result_t r;
        r.kind  = kind;
        r.x     = x[31:0];
        r.y     = y[31:0];
        r.w     = w[31:0];
        r.h     = h[31:0];
        r.first = first;
        r.last  = 1'b0;
        lowered_q.insert(lowered_q.size(), r);
    endfunction

    // expected results of one geometry element
    function automatic void lower_element(logic [4:0] user, logic lastf, logic [127:0] d);
        logic [1:0] op, pk;
        logic       firstf;
        longint     ax, ay, bx, by, x, y, x2, y2, rx, ry, lx, hx, ly, hy, kx, ky, px, py;
        bit         axis;
        longint     offx[5], offy[5], cxs[4], cys[4];
        int         ax_tab[13], ay_tab[13];
        op     = user[1:0];
        pk     = user[3:2];
        firstf = user[4];
        ax = longint'($signed(d[31:0]));
        ay = longint'($signed(d[63:32]));
        bx = longint'($signed(d[95:64]));
        by = longint'($signed(d[127:96]));
        axis = (m_xy == 0) && (m_yx == 0);
        ax_tab = '{0, 0, 1, 2, 3, 4, 4, 4, 3, 2, 1, 0, 0};
        ay_tab = '{2, 1, 0, 0, 0, 1, 2, 3, 4, 4, 4, 3, 2};
        x = ax;
        y = ay;
        case (op)
            OP_PATH:
            begin
                if (pk == PK_CLOSE)
                    add_result(K_CLOSE, 0, 0, 0, 0, 1'b0);
                else
                begin
                    if (!m_same)
                        map_point(ax, ay, x, y);
                    add_result(3'(pk) + 3'd1, x, y, 0, 0, (pk == PK_BEZ) ? firstf : 1'b0);
                end
            end
            OP_POLY:
            begin
                if (m_same)
                    add_result(K_POLY, x, y, 0, 0, 1'b0);
                else if (axis)
                begin
                    map_point(ax, ay, x, y);
                    add_result(K_POLY, x, y, 0, 0, 1'b0);
                end
                else
                begin
                    map_point(ax, ay, x, y);
                    add_result(firstf ? K_MOVE : K_LINE, x, y, 0, 0, 1'b0);
                    if (lastf)
                        add_result(K_CLOSE, 0, 0, 0, 0, 1'b0);
                end
            end
            OP_RECT:
            begin
                rx = clamp32(ax + bx);
                ry = clamp32(ay + by);
                if (m_same)
                    add_result(K_RECT, ax, ay, bx, by, 1'b0);
                else if (axis)
                begin
                    map_point(ax, ay, x, y);
                    map_point(rx, ry, x2, y2);
                    lx = (x < x2) ? x : x2;
                    hx = (x < x2) ? x2 : x;
                    ly = (y < y2) ? y : y2;
                    hy = (y < y2) ? y2 : y;
                    add_result(K_RECT, lx, ly, clamp32(hx - lx), clamp32(hy - ly), 1'b0);
                end
                else
                begin
                    cxs = '{ax, rx, rx, ax};
                    cys = '{ay, ay, ry, ry};
                    for (int i = 0; i < 4; i++)
                    begin
                        map_point(cxs[i], cys[i], x, y);
                        add_result((i == 0) ? K_MOVE : K_LINE, x, y, 0, 0, 1'b0);
                    end
                    add_result(K_CLOSE, 0, 0, 0, 0, 1'b0);
                end
            end
            default:
            begin
                if (m_same)
                    add_result(K_ELL, ax, ay, bx, by, 1'b0);
                else if (axis)
                begin
                    map_point(ax, ay, x, y);
                    add_result(K_ELL, x, y,
                               round_q(((m_xx < 0) ? -m_xx : m_xx) * bx),
                               round_q(((m_yy < 0) ? -m_yy : m_yy) * by), 1'b0);
                end
                else
                begin
                    // four cubic arcs around the center
                    kx = round_q(bx * KAPPA_FX);
                    ky = round_q(by * KAPPA_FX);
                    offx = '{bx, kx, 0, -kx, -bx};
                    offy = '{by, ky, 0, -ky, -by};
                    for (int i = 0; i < 13; i++)
                    begin
                        px = clamp32(ax + offx[ax_tab[i]]);
                        py = clamp32(ay + offy[ay_tab[i]]);
                        map_point(px, py, x, y);
                        if (i == 0)
                            add_result(K_MOVE, x, y, 0, 0, 1'b0);
                        else
                            add_result(K_BEZ, x, y, 0, 0, ((i - 1) % 3) == 0);
                    end
                    add_result(K_CLOSE, 0, 0, 0, 0, 1'b0);
                end
            end
        endcase
        lowered_q[lowered_q.size() - 1].last = 1'b1;
    endfunction

    // register writes, accepted elements and results
    always @(posedge clk or negedge rst_n)
    begin
        shape_result_t e;
        if (!rst_n)
        begin
            m_xx = ONE_Q;
            m_xy = 0;
            m_yx = 0;
            m_yy = ONE_Q;
            m_tx = 0;
            m_ty = 0;
            m_same = 1'b0;
            fail_count = 0;
            lowered_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_XX:   m_xx = longint'($signed(cfg_data));
                    REG_XY:   m_xy = longint'($signed(cfg_data));
                    REG_YX:   m_yx = longint'($signed(cfg_data));
                    REG_YY:   m_yy = longint'($signed(cfg_data));
                    REG_TX:   m_tx = longint'($signed(cfg_data));
                    REG_TY:   m_ty = longint'($signed(cfg_data));
                    REG_SAME: m_same = cfg_data[0];
                    default:  ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (lowered_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d x %h", m_tuser[2:0], m_tdata[31:0]);
                    fail_count++;
                end
                else
                begin
                    e = lowered_q.pop_front();
                    if (m_tuser[2:0] !== e.kind)
                    begin
                        $error("out_kind: expected %0d, got %0d", e.kind, m_tuser[2:0]);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== e.x)
                    begin
                        $error("out_x: expected %h, got %h", e.x, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== e.y)
                    begin
                        $error("out_y: expected %h, got %h", e.y, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== e.w)
                    begin
                        $error("out_w: expected %h, got %h", e.w, m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tdata[127:96] !== e.h)
                    begin
                        $error("out_h: expected %h, got %h", e.h, m_tdata[127:96]);
                        fail_count++;
                    end
                    if (m_tuser[3] !== e.first)
                    begin
                        $error("out_first: expected %b, got %b", e.first, m_tuser[3]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("out_last: expected %b, got %b", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                lower_element(s_tuser, s_tlast, s_tdata);
        end
        pending = lowered_q.size();
    end

endmodule

// ===== tb/sv/tb_affine_shape_to_path_lowering_top.sv =====
// Testbench top: stimulus, register phases, output back-pressure and verdict.
module tb_affine_shape_to_path_lowering_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aspl_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam logic [31:0] Q_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] Q_MIN = 32'h80000000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [4:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           cycles;
    int           burst_left;
    bit           hold_request;

    affine_shape_to_path_lowering_top i_dut (.*);

    aspl_checker i_checker (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls in stretches, plus one long hold on request
    initial
    begin
        int mode;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 40; i++)
            begin
                @(posedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    m_tready <= 1'b0;
                    repeat (150) @(posedge clk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one element, with bursts separated by gaps
    task automatic offer_element(logic [1:0] op, logic [1:0] pk, logic fl, logic ll,
                                 logic [31:0] ax, logic [31:0] ay,
                                 logic [31:0] bx, logic [31:0] by);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= {fl, pk, op};
        s_tlast  <= ll;
        s_tdata  <= {by, bx, ay, ax};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
        endcase
    endfunction

    task automatic random_elements(int count);
        for (int i = 0; i < count; i++)
            offer_element(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          1'($urandom), 1'($urandom), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord());
    endtask

    // wait for every result, then for the pipeline to settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_transform(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
                                  logic [31:0] yy, logic [31:0] tx, logic [31:0] ty,
                                  logic same);
        write_reg(REG_XX, xx);
        write_reg(REG_XY, xy);
        write_reg(REG_YX, yx);
        write_reg(REG_YY, yy);
        write_reg(REG_TX, tx);
        write_reg(REG_TY, ty);
        write_reg(REG_SAME, {31'd0, same});
    endtask

    // extremes, every path kind, polygons with first and last, shapes
    task automatic directed_elements();
        for (int k = 0; k < 4; k++)
            offer_element(OP_PATH, 2'(k), 1'b1, 1'b1, 32'h00018000, 32'hFFFE8000, 0, 0);
        offer_element(OP_PATH, PK_BEZ, 1'b0, 1'b0, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        offer_element(OP_POLY, 2'd0, 1'b1, 1'b0, 32'h00010000, 32'h00020000, 0, 0);
        offer_element(OP_POLY, 2'd0, 1'b0, 1'b0, Q_MIN, Q_MAX, 0, 0);
        offer_element(OP_POLY, 2'd0, 1'b0, 1'b1, 32'hFFFF0000, 0, 0, 0);
        offer_element(OP_RECT, 2'd0, 1'b0, 1'b0, 32'h00010000, 32'h00010000,
                      32'h00050000, 32'h00030000);
        offer_element(OP_RECT, 2'd0, 1'b0, 1'b0, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        offer_element(OP_RECT, 2'd0, 1'b0, 1'b0, 0, 0, 32'hFFFD0000, 32'hFFFE0000);
        offer_element(OP_ELL, 2'd0, 1'b0, 1'b0, 0, 0, 32'h00040000, 32'h00020000);
        offer_element(OP_ELL, 2'd0, 1'b0, 1'b0, Q_MAX, Q_MIN, Q_MIN, Q_MAX);
        offer_element(OP_ELL, 2'd0, 1'b0, 1'b0, 32'h00008000, 32'hFFFF8000,
                      32'hFFFC0000, 32'h00010000);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        s_tlast      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_XX;
        cfg_data     <= '0;
        burst_left   = 0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset transform
        directed_elements();
        random_elements(20);
        drain();

        // sheared transform, with the long output hold while input keeps coming
        load_transform(32'h00012000, 32'hFFFF4000, 32'h00008000, 32'h0000C000,
                       32'h00100000, 32'hFFE00000, 1'b0);
        directed_elements();
        hold_request = 1'b1;
        random_elements(30);
        drain();

        // bypass
        load_transform(32'h00030000, 32'h00010000, 0, 32'h00020000, 32'h00050000,
                       32'h00070000, 1'b1);
        directed_elements();
        random_elements(20);
        drain();

        // axis aligned with a negative x scale
        load_transform(32'hFFFD8000, 0, 0, 32'h0000C000, 32'hFFF80000, 32'h00030000, 1'b0);
        directed_elements();
        random_elements(30);
        drain();

        // extreme coefficients
        load_transform(Q_MAX, Q_MIN, 32'h00000001, Q_MIN, Q_MAX, Q_MIN, 1'b0);
        random_elements(25);
        drain();

        // extreme axis scales
        load_transform(Q_MIN, 0, 0, Q_MAX, Q_MIN, Q_MAX, 1'b0);
        random_elements(25);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
